[sv/rovt_pkg.sv]
`default_nettype none

package rovt_pkg;

    localparam int COORD_WIDTH_DEFAULT = 16;

    typedef enum logic [1:0] {
        ORI_ZERO,
        ORI_POS,
        ORI_NEG
    } t_orient;

    // True when the product of the two orientations is zero or negative.
    function automatic logic ori_straddle(input t_orient a, input t_orient b);
        return !(((a == ORI_POS) && (b == ORI_POS)) || ((a == ORI_NEG) && (b == ORI_NEG)));
    endfunction

endpackage

`default_nettype wire

[sv/rectangle_overlap_test_core.sv]
`default_nettype none

// Throughput: one rectangle pair per cycle while the output is not stalled, set by four register
// stages (input, coordinate differences, orientations, result) joined by a ready chain; the result
// is offered on o_valid from the result stage. A stalled output holds each full stage that has no
// empty stage downstream of it, and the pipeline keeps accepting while any stage is empty.
// Reset clears only the stage valid bits; data registers keep whatever they hold.
module rectangle_overlap_test_core #(
    parameter int COORD_WIDTH = rovt_pkg::COORD_WIDTH_DEFAULT
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_valid,
    output logic                         o_ready,
    input  wire signed [COORD_WIDTH-1:0] i_a_left,
    input  wire signed [COORD_WIDTH-1:0] i_a_top,
    input  wire signed [COORD_WIDTH-1:0] i_a_right,
    input  wire signed [COORD_WIDTH-1:0] i_a_bottom,
    input  wire signed [COORD_WIDTH-1:0] i_b_left,
    input  wire signed [COORD_WIDTH-1:0] i_b_top,
    input  wire signed [COORD_WIDTH-1:0] i_b_right,
    input  wire signed [COORD_WIDTH-1:0] i_b_bottom,
    output logic                         o_valid,
    input  wire                          i_ready,
    output logic                         o_overlaps
);
    import rovt_pkg::*;

    localparam int W = COORD_WIDTH;

    function automatic logic in_span(input logic signed [W-1:0] v,
                                     input logic signed [W-1:0] a,
                                     input logic signed [W-1:0] b);
        return (a <= b) ? ((v >= a) && (v <= b)) : ((v >= b) && (v <= a));
    endfunction

    function automatic logic [W-1:0] mag(input logic [W-1:0] v);
        return v[W-1] ? (~v + {{(W-1){1'b0}}, 1'b1}) : v;
    endfunction

    // Orientation against an axis-aligned edge. u is the edge's only nonzero-capable
    // component, v2 the corner offset along the edge's axis, w2 across it.
    function automatic t_orient orient_axis(input logic [W-1:0] u,
                                            input logic [W-1:0] v2,
                                            input logic [W-1:0] w2,
                                            input logic vert);
        logic    u_nz;
        logic    v_nz;
        logic    w_nz;
        t_orient res;
        u_nz = (u != '0);
        v_nz = (v2 != '0);
        w_nz = (w2 != '0);
        if (u_nz && w_nz) begin
            res = ((u[W-1] == w2[W-1]) ^ vert) ? ORI_POS : ORI_NEG;
        end else if (u_nz && v_nz && (u[W-1] != v2[W-1])) begin
            res = ORI_NEG;
        end else if (!u_nz) begin
            res = (v_nz || w_nz) ? ORI_POS : ORI_ZERO;
        end else begin
            res = (mag(u) < mag(v2)) ? ORI_POS : ORI_ZERO;
        end
        return res;
    endfunction

    logic ld0, ld1, ld2, ld3;
    logic r_v0, r_v1, r_v2, r_v3;

    logic signed [W-1:0] r_rect [2][4];

    logic [W-1:0] n_u  [2][4];
    logic [W-1:0] r_u  [2][4];
    logic [W-1:0] n_dx [2][4][4];
    logic [W-1:0] r_dx [2][4][4];
    logic [W-1:0] n_dy [2][4][4];
    logic [W-1:0] r_dy [2][4][4];
    logic [1:0]   n_cont;
    logic [1:0]   r_cont1;
    logic         r_cont2;

    t_orient n_ori [2][4][4];
    t_orient r_ori [2][4][4];

    logic [15:0] meet;
    logic        n_hit;
    logic        r_overlaps;

    assign ld3     = !r_v3 || i_ready;
    assign ld2     = !r_v2 || ld3;
    assign ld1     = !r_v1 || ld2;
    assign ld0     = !r_v0 || ld1;
    assign o_ready = ld0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (ld0) begin
                r_v0 <= i_valid;
            end
            if (ld1) begin
                r_v1 <= r_v0;
            end
            if (ld2) begin
                r_v2 <= r_v1;
            end
            if (ld3) begin
                r_v3 <= r_v2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld0 && i_valid) begin
            r_rect[0][0] <= i_a_left;
            r_rect[0][1] <= i_a_top;
            r_rect[0][2] <= i_a_right;
            r_rect[0][3] <= i_a_bottom;
            r_rect[1][0] <= i_b_left;
            r_rect[1][1] <= i_b_top;
            r_rect[1][2] <= i_b_right;
            r_rect[1][3] <= i_b_bottom;
        end
        if (ld1 && r_v0) begin
            r_u     <= n_u;
            r_dx    <= n_dx;
            r_dy    <= n_dy;
            r_cont1 <= n_cont;
        end
        if (ld2 && r_v1) begin
            r_ori   <= n_ori;
            r_cont2 <= |r_cont1;
        end
        if (ld3 && r_v2) begin
            r_overlaps <= n_hit;
        end
    end

    // Corner k of a rectangle: 0 is (left, top), 1 (right, top), 2 (right, bottom),
    // 3 (left, bottom). Edge i runs from corner i to the next corner.
    for (genvar p = 0; p < 2; p++) begin : g_rect
        localparam int Q = 1 - p;
        for (genvar i = 0; i < 4; i++) begin : g_edge
            localparam int  I1   = (i + 1) % 4;
            localparam int  CX0  = ((i == 0) || (i == 3)) ? 0 : 2;
            localparam int  CY0  = (i < 2) ? 1 : 3;
            localparam int  CX1  = ((I1 == 0) || (I1 == 3)) ? 0 : 2;
            localparam int  CY1  = (I1 < 2) ? 1 : 3;
            localparam bit  VERT = (i % 2) == 1;

            assign n_u[p][i] = VERT ? (r_rect[p][CY1] - r_rect[p][CY0])
                                    : (r_rect[p][CX1] - r_rect[p][CX0]);

            for (genvar k = 0; k < 4; k++) begin : g_corner
                localparam int KX = ((k == 0) || (k == 3)) ? 0 : 2;
                localparam int KY = (k < 2) ? 1 : 3;

                assign n_dx[p][i][k] = r_rect[Q][KX] - r_rect[p][CX0];
                assign n_dy[p][i][k] = r_rect[Q][KY] - r_rect[p][CY0];

                assign n_ori[p][i][k] = VERT
                    ? orient_axis(r_u[p][i], r_dy[p][i][k], r_dx[p][i][k], 1'b1)
                    : orient_axis(r_u[p][i], r_dx[p][i][k], r_dy[p][i][k], 1'b0);
            end
        end
    end

    assign n_cont[0] = in_span(r_rect[0][0], r_rect[1][0], r_rect[1][2])
                    && in_span(r_rect[0][1], r_rect[1][1], r_rect[1][3]);
    assign n_cont[1] = in_span(r_rect[1][0], r_rect[0][0], r_rect[0][2])
                    && in_span(r_rect[1][1], r_rect[0][1], r_rect[0][3]);

    for (genvar i = 0; i < 4; i++) begin : g_meet_a
        for (genvar j = 0; j < 4; j++) begin : g_meet_b
            localparam int I1 = (i + 1) % 4;
            localparam int J1 = (j + 1) % 4;
            assign meet[i*4 + j] = ori_straddle(r_ori[0][i][j], r_ori[0][i][J1])
                                && ori_straddle(r_ori[1][j][i], r_ori[1][j][I1]);
        end
    end

    assign n_hit      = (|meet) || r_cont2;
    assign o_valid    = r_v3;
    assign o_overlaps = r_overlaps;

    a_idle_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("Pipeline refused a transfer with the output stage empty.");

    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v0 && r_v1 && r_v2 && r_v3 && !i_ready) |-> !o_ready)
        else $error("Pipeline accepted a transfer while every stage was held.");

    a_accept_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> r_v0)
        else $error("Accepted input did not reach the first stage.");

    a_cont_carry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v1 && (|r_cont1) && ld2) |=> (r_v2 && r_cont2))
        else $error("Containment hit was lost between stages.");

endmodule

`default_nettype wire

[test/testbench.sv]
`timescale 1ns / 1ps

module testbench;
    import rovt_pkg::*;

    localparam int CW = COORD_WIDTH_DEFAULT;

    typedef logic signed [CW-1:0] t_coord;

    typedef struct packed {
        t_coord a_left;
        t_coord a_top;
        t_coord a_right;
        t_coord a_bottom;
        t_coord b_left;
        t_coord b_top;
        t_coord b_right;
        t_coord b_bottom;
    } t_rect_pair;

    class t_rect_overlap_scoreboard;
        bit expected_overlaps[$];
        int mismatch_count = 0;

        function longint wrap_diff(t_coord a, t_coord b);
            t_coord d;
            d = a - b;
            return longint'(d);
        endfunction

        function t_orient orientation(t_coord x0, t_coord y0, t_coord x1, t_coord y1,
                                      t_coord x2, t_coord y2);
            longint dx1, dy1, dx2, dy2;
            dx1 = wrap_diff(x1, x0);
            dy1 = wrap_diff(y1, y0);
            dx2 = wrap_diff(x2, x0);
            dy2 = wrap_diff(y2, y0);
            if (dx1 * dy2 > dy1 * dx2) return ORI_POS;
            if (dx1 * dy2 < dy1 * dx2) return ORI_NEG;
            if ((dx1 > 0 && dx2 < 0) || (dx1 < 0 && dx2 > 0) ||
                (dy1 > 0 && dy2 < 0) || (dy1 < 0 && dy2 > 0)) return ORI_NEG;
            if (dx1 * dx1 + dy1 * dy1 < dx2 * dx2 + dy2 * dy2) return ORI_POS;
            return ORI_ZERO;
        endfunction

        // The product of the two orientations is zero or negative.
        function bit straddles(t_orient a, t_orient b);
            return (a == ORI_ZERO) || (b == ORI_ZERO) || (a != b);
        endfunction

        function bit in_span(t_coord v, t_coord a, t_coord b);
            return (a <= b) ? (v >= a && v <= b) : (v >= b && v <= a);
        endfunction

        function bit predict_overlap(t_rect_pair p);
            t_coord c[2][4];
            t_coord px[2][4];
            t_coord py[2][4];
            int     k, v, i, j, i1, j1;
            bit     hit;
            c[0][0] = p.a_left;  c[0][1] = p.a_top;  c[0][2] = p.a_right;  c[0][3] = p.a_bottom;
            c[1][0] = p.b_left;  c[1][1] = p.b_top;  c[1][2] = p.b_right;  c[1][3] = p.b_bottom;
            // Corners in edge order: top left, top right, bottom right, bottom left.
            for (k = 0; k < 2; k++) begin
                for (v = 0; v < 4; v++) begin
                    px[k][v] = c[k][(v == 1 || v == 2) ? 2 : 0];
                    py[k][v] = c[k][(v < 2) ? 1 : 3];
                end
            end
            hit = 1'b0;
            for (i = 0; i < 4; i++) begin
                for (j = 0; j < 4; j++) begin
                    i1 = (i + 1) % 4;
                    j1 = (j + 1) % 4;
                    if (straddles(orientation(px[0][i], py[0][i], px[0][i1], py[0][i1],
                                              px[1][j], py[1][j]),
                                  orientation(px[0][i], py[0][i], px[0][i1], py[0][i1],
                                              px[1][j1], py[1][j1])) &&
                        straddles(orientation(px[1][j], py[1][j], px[1][j1], py[1][j1],
                                              px[0][i], py[0][i]),
                                  orientation(px[1][j], py[1][j], px[1][j1], py[1][j1],
                                              px[0][i1], py[0][i1])))
                        hit = 1'b1;
                end
            end
            if (!hit) begin
                if (in_span(p.a_left, p.b_left, p.b_right) && in_span(p.a_top, p.b_top, p.b_bottom))
                    hit = 1'b1;
                else if (in_span(p.b_left, p.a_left, p.a_right) &&
                         in_span(p.b_top, p.a_top, p.a_bottom))
                    hit = 1'b1;
            end
            return hit;
        endfunction

        function void note_pair(t_rect_pair p);
            expected_overlaps.push_back(predict_overlap(p));
        endfunction

        function void check_overlap(bit got);
            bit want;
            if (expected_overlaps.size() == 0) begin
                $error("overlaps: no result expected, got %0b", got);
                mismatch_count++;
            end else begin
                want = expected_overlaps.pop_front();
                if (want !== got) begin
                    $error("overlaps: expected %0b, got %0b", want, got);
                    mismatch_count++;
                end
            end
        endfunction
    endclass

    logic   i_clk;
    logic   i_rst_n;
    logic   i_valid;
    logic   o_ready;
    t_coord i_a_left, i_a_top, i_a_right, i_a_bottom;
    t_coord i_b_left, i_b_top, i_b_right, i_b_bottom;
    logic   o_valid;
    logic   i_ready;
    logic   o_overlaps;

    int src_idle_pct = 21;
    int snk_idle_pct = 48;

    t_rect_overlap_scoreboard sb = new;

    rectangle_overlap_test_core #(
        .COORD_WIDTH(CW)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_a_left   (i_a_left),
        .i_a_top    (i_a_top),
        .i_a_right  (i_a_right),
        .i_a_bottom (i_a_bottom),
        .i_b_left   (i_b_left),
        .i_b_top    (i_b_top),
        .i_b_right  (i_b_right),
        .i_b_bottom (i_b_bottom),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_overlaps (o_overlaps)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(0, 99) >= snk_idle_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && o_ready)
                sb.note_pair(t_rect_pair'({i_a_left, i_a_top, i_a_right, i_a_bottom,
                                           i_b_left, i_b_top, i_b_right, i_b_bottom}));
            if (o_valid && i_ready)
                sb.check_overlap(o_overlaps);
        end
    end

    function automatic t_rect_pair mk(int al, int at, int ar, int ab,
                                      int bl, int bt, int br, int bb);
        return {t_coord'(al), t_coord'(at), t_coord'(ar), t_coord'(ab),
                t_coord'(bl), t_coord'(bt), t_coord'(br), t_coord'(bb)};
    endfunction

    task automatic drive_pair(input t_rect_pair p);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_a_left   <= p.a_left;
        i_a_top    <= p.a_top;
        i_a_right  <= p.a_right;
        i_a_bottom <= p.a_bottom;
        i_b_left   <= p.b_left;
        i_b_top    <= p.b_top;
        i_b_right  <= p.b_right;
        i_b_bottom <= p.b_bottom;
        do @(posedge i_clk); while (!o_ready);
    endtask

    initial begin
        t_rect_pair p;
        int         v[8];
        int         base[2];
        int         k, n, sel, phase, t;
        int         edge_vals[8];

        edge_vals  = '{-32768, -32767, -2, -1, 0, 1, 32766, 32767};
        i_rst_n    = 1'b0;
        i_valid    = 1'b0;
        i_a_left   = '0;
        i_a_top    = '0;
        i_a_right  = '0;
        i_a_bottom = '0;
        i_b_left   = '0;
        i_b_top    = '0;
        i_b_right  = '0;
        i_b_bottom = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        drive_pair(mk(0, 0, 0, 0, 0, 0, 0, 0));
        drive_pair(mk(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768));
        drive_pair(mk(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767));
        drive_pair(mk(-32768, -32768, 32767, 32767, 0, 0, 1, 1));
        drive_pair(mk(-32768, 32767, 32767, -32768, -32768, -32768, 32767, 32767));
        drive_pair(mk(32760, 32760, 32767, 32767, -32768, -32768, -32760, -32760));
        drive_pair(mk(32767, 0, -32768, 0, 0, -32768, 0, 32767));
        drive_pair(mk(0, 0, 10, 10, 20, 20, 30, 30));
        drive_pair(mk(0, 0, 10, 10, 5, -5, 15, 5));
        drive_pair(mk(0, 0, 100, 100, 10, 10, 20, 20));
        drive_pair(mk(100, 100, 0, 0, 20, 20, 10, 10));
        drive_pair(mk(10, 10, 20, 20, 0, 0, 100, 100));
        drive_pair(mk(20, 20, 10, 10, 100, 100, 0, 0));
        drive_pair(mk(0, 0, 10, 10, 10, 0, 20, 10));
        drive_pair(mk(0, 0, 10, 10, 10, 10, 20, 20));
        drive_pair(mk(0, 0, 10, 10, 11, 11, 20, 20));
        drive_pair(mk(0, 0, 10, 5, 5, 0, 15, -5));
        drive_pair(mk(0, 0, 10, 5, 11, 0, 20, 5));
        drive_pair(mk(5, 0, 5, 10, 0, 3, 10, 7));
        drive_pair(mk(5, 5, 5, 5, 0, 0, 10, 10));
        drive_pair(mk(0, 0, 0, 0, 0, 0, 10, 10));
        drive_pair(mk(0, 0, 10, 0, -5, 0, 20, 0));
        drive_pair(mk(0, 0, 10, 0, 11, 0, 20, 0));
        drive_pair(mk(-5, 3, -5, 3, 7, 9, 7, 9));

        for (phase = 0; phase < 3; phase++) begin
            src_idle_pct = (phase == 0) ? 21 : (phase == 1) ? 48 : 0;
            snk_idle_pct = (phase == 0) ? 48 : (phase == 1) ? 21 : 0;
            for (n = 0; n < 300; n++) begin
                sel     = $urandom_range(0, 99);
                base[0] = $urandom_range(0, 65535);
                base[1] = $urandom_range(0, 65535);
                if (sel < 35) begin
                    for (k = 0; k < 8; k++) v[k] = int'($urandom_range(0, 80)) - 40;
                end else if (sel < 50) begin
                    // One rectangle holds the other; corner order and roles are shuffled.
                    for (k = 0; k < 2; k++) begin
                        v[k]     = 50 - int'($urandom_range(100, 350));
                        v[k + 2] = $urandom_range(50, 300);
                        v[k + 4] = int'($urandom_range(0, 100)) - 50;
                        v[k + 6] = int'($urandom_range(0, 100)) - 50;
                    end
                    if ($urandom_range(0, 1)) begin
                        t = v[0]; v[0] = v[2]; v[2] = t;
                        t = v[1]; v[1] = v[3]; v[3] = t;
                    end
                    if ($urandom_range(0, 1)) begin
                        for (k = 0; k < 4; k++) begin
                            t = v[k]; v[k] = v[k + 4]; v[k + 4] = t;
                        end
                    end
                end else if (sel < 70) begin
                    // The second rectangle reuses coordinates of the first on the same axis.
                    for (k = 0; k < 4; k++) v[k] = int'($urandom_range(0, 60)) - 30;
                    for (k = 4; k < 8; k++) begin
                        v[k] = v[(k - 4) ^ (2 * $urandom_range(0, 1))];
                        if ($urandom_range(0, 3) == 0) v[k] += int'($urandom_range(0, 2)) - 1;
                    end
                end else if (sel < 90) begin
                    for (k = 0; k < 8; k++) v[k] = $urandom;
                end else begin
                    base[0] = 0;
                    base[1] = 0;
                    for (k = 0; k < 8; k++) v[k] = edge_vals[$urandom_range(0, 7)];
                end
                for (k = 0; k < 8; k++) p[(7 - k) * CW +: CW] = t_coord'(v[k] + base[k % 2]);
                drive_pair(p);
            end
        end
        i_valid <= 1'b0;

        n = 0;
        while (sb.expected_overlaps.size() != 0 && n < 5000) begin
            @(posedge i_clk);
            n++;
        end
        repeat (10) @(posedge i_clk);
        if (sb.expected_overlaps.size() != 0) begin
            $error("overlaps: %0d results never arrived", sb.expected_overlaps.size());
            sb.mismatch_count++;
        end
        if (sb.mismatch_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

[files.f]
sv/rovt_pkg.sv
sv/rectangle_overlap_test_core.sv
test/testbench.sv
